// ===== rtl/core/kctt_pkg.sv =====
// ----------------------------------------------------------------------------
// kctt_pkg
// Shared types, constants and helpers of the keyed confidence tracking table.
// ----------------------------------------------------------------------------
package kctt_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 2048;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int EVENT_KINDS   = 32;

   // fixed point constants
   localparam logic [16:0] Q16_ONE    = 17'd65536;
   localparam logic [19:0] HIT_WEIGHT = 20'd1966;   // 0.03 in Q16
   localparam logic [7:0]  HITS_MAX   = 8'd255;
   localparam int          RANK_W     = 20;
   localparam int          PROD_W     = 34;

   // register map, one register every eight bytes
   localparam int CSR_ADDR_W = 6;
   typedef enum logic [2:0] {
      REG_PROMOTABLE_MASK = 3'd0,
      REG_MIN_HITS        = 3'd1,
      REG_MAX_AGE_US      = 3'd2,
      REG_MIN_CONFIDENCE  = 3'd3,
      REG_ACCEPT_FLOOR    = 3'd4,
      REG_SMOOTHING_ALPHA = 3'd5,
      REG_SWITCH_MARGIN   = 3'd6,
      REG_DECAY_STEP      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [31:0] promotable_mask;
      logic [7:0]  min_hits;
      logic [39:0] max_age_us;
      logic [16:0] min_confidence;
      logic [16:0] accept_floor;
      logic [16:0] smoothing_alpha;
      logic [16:0] switch_margin;
      logic [16:0] decay_step;
   } cfg_type;

   // classification made by the front end
   typedef enum logic [1:0] {
      OP_IGNORE  = 2'd0,   // observe that leaves the table alone
      OP_OBSERVE = 2'd1,
      OP_QUERY   = 2'd2,
      OP_SKIP    = 2'd3    // query with key zero
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [4:0]  kind;
      logic [16:0] conf;   // already clamped to 1.0
      logic [63:0] now;
   } item_type;

   typedef struct packed {
      logic [31:0] key;
      logic [4:0]  kind;
      logic [16:0] conf;
      logic [7:0]  hits;
      logic [63:0] last_seen;
   } entry_type;

   typedef struct packed {
      logic        accepted;
      logic        promoted;
      logic [4:0]  promoted_kind;
      logic [16:0] promoted_confidence;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_SCAN  = 3'd1,
      ST_EVAL  = 3'd2,
      ST_MUL   = 3'd3,
      ST_BLEND = 3'd4,
      ST_DONE  = 3'd5
   } back_state_type;

   function automatic logic kind_ok(input logic [31:0] mask, input logic [4:0] kind);
      logic ok;
      ok = (int'(kind) < EVENT_KINDS) && mask[kind];
      return ok;
   endfunction

endpackage

// ===== rtl/core/kctt_front.sv =====
// ----------------------------------------------------------------------------
// kctt_front
// Takes input words, classifies them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module kctt_front import kctt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        push,
   output logic        full,
   input  logic        action,
   input  logic [31:0] form_id,
   input  logic [4:0]  event_kind,
   input  logic [16:0] confidence_in,
   input  logic [63:0] now_us,
   input  logic        q_pop,
   output logic        q_valid,
   output item_type    q_item
);

   item_type    slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   item_type    cls;
   logic [16:0] conf_clamped;
   logic        do_push;
   logic        do_pop;

   // classify the incoming word
   always_comb begin
      conf_clamped = (confidence_in > Q16_ONE) ? Q16_ONE : confidence_in;
      cls.key  = form_id;
      cls.kind = event_kind;
      cls.conf = conf_clamped;
      cls.now  = now_us;
      if (action == 1'b0) begin
         if (form_id == 32'd0 || !kind_ok(cfg.promotable_mask, event_kind) ||
             conf_clamped < cfg.accept_floor) begin
            cls.op = OP_IGNORE;
         end else begin
            cls.op = OP_OBSERVE;
         end
      end else begin
         cls.op = (form_id == 32'd0) ? OP_SKIP : OP_QUERY;
      end
   end

   assign full    = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   // queue pointers
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/core/kctt_back.sv =====
// ----------------------------------------------------------------------------
// kctt_back
// Runs one word at a time against the slot memory: key scan with eviction
// ranking, then create, restart, blend, replace, decay or promote.
// ----------------------------------------------------------------------------
module kctt_back import kctt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output result_type       rsp,
   output logic [CNT_W-1:0] occupied
);

   // slot memory; slots 0 .. count-1 are the valid ones
   entry_type            mem [TABLE_ENTRIES];

   back_state_type       state_ff, state_in;
   item_type             item_ff, item_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   entry_type            rd_data_ff;
   entry_type            hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                 found_ff, found_in;
   logic [RANK_W-1:0]    best_rank_ff, best_rank_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [PROD_W-1:0]    p1_ff, p1_in;
   logic [PROD_W-1:0]    p2_ff, p2_in;
   result_type           res_ff, res_in;
   result_type           out_ff, out_in;
   logic                 out_vld_ff, out_vld_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;
   logic [RANK_W-1:0]    rank;
   logic [63:0]          age;
   logic                 expired;
   logic [16:0]          alpha;
   logic [PROD_W:0]      blend_sum;
   logic [18:0]          blend_q;
   logic [17:0]          switch_lvl;

   assign empty    = !out_vld_ff;
   assign rsp      = out_ff;
   assign occupied = count_ff;

   // datapath helpers
   always_comb begin
      rank       = {3'd0, rd_data_ff.conf} + RANK_W'(rd_data_ff.hits) * HIT_WEIGHT;
      age        = item_ff.now - hit_ff.last_seen;
      expired    = (item_ff.now > hit_ff.last_seen) && (age > {24'd0, cfg.max_age_us});
      alpha      = (cfg.smoothing_alpha > Q16_ONE) ? Q16_ONE : cfg.smoothing_alpha;
      blend_sum  = {1'b0, p1_ff} + {1'b0, p2_ff} + (PROD_W + 1)'(32768);
      blend_q    = blend_sum[34:16];
      switch_lvl = {1'b0, hit_ff.conf} + {1'b0, cfg.switch_margin};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      issue_in     = issue_ff;
      count_in     = count_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      found_in     = found_ff;
      best_rank_in = best_rank_ff;
      best_idx_in  = best_idx_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_data      = hit_ff;

      if (pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               item_in      = q_item;
               found_in     = 1'b0;
               best_rank_in = '1;
               best_idx_in  = '0;
               issue_in     = '0;
               res_in       = '0;
               if (q_item.op inside {OP_IGNORE, OP_SKIP}) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // one read issued a cycle, compared in the cycle after
            if (issue_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IDX_W-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rank < best_rank_ff) begin
                  best_rank_in = rank;
                  best_idx_in  = rd_idx_ff;
               end
               if (rd_data_ff.key == item_ff.key) begin
                  found_in   = 1'b1;
                  hit_in     = rd_data_ff;
                  hit_idx_in = rd_idx_ff;
                  rd_vld_in  = 1'b0;
                  state_in   = ST_EVAL;
               end
            end else if (!(issue_ff < count_ff)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_DONE;
            if (item_ff.op == OP_QUERY) begin
               if (found_ff && kind_ok(cfg.promotable_mask, hit_ff.kind) && !expired &&
                   hit_ff.hits >= cfg.min_hits && hit_ff.conf >= cfg.min_confidence) begin
                  res_in.promoted            = 1'b1;
                  res_in.promoted_kind       = hit_ff.kind;
                  res_in.promoted_confidence = hit_ff.conf;
               end
            end else if (!found_ff) begin
               // new key: next free slot, else the lowest ranked one
               wr_en          = 1'b1;
               wr_data.key    = item_ff.key;
               wr_data.kind   = item_ff.kind;
               wr_data.conf   = item_ff.conf;
               wr_data.hits   = 8'd1;
               wr_data.last_seen = item_ff.now;
               if (count_ff < CNT_W'(TABLE_ENTRIES)) begin
                  wr_addr  = count_ff[IDX_W-1:0];
                  count_in = count_ff + 1'b1;
               end else begin
                  wr_addr = best_idx_ff;
               end
               res_in.accepted = 1'b1;
            end else if (expired || (hit_ff.kind != item_ff.kind &&
                                     {1'b0, item_ff.conf} >= switch_lvl)) begin
               // restart or replace
               wr_en             = 1'b1;
               wr_data.kind      = item_ff.kind;
               wr_data.conf      = item_ff.conf;
               wr_data.hits      = 8'd1;
               wr_data.last_seen = item_ff.now;
               res_in.accepted   = 1'b1;
            end else if (hit_ff.kind == item_ff.kind) begin
               state_in = ST_MUL;
            end else begin
               // weak conflicting kind: decay
               wr_en             = 1'b1;
               wr_data.conf      = (hit_ff.conf > cfg.decay_step) ?
                                   hit_ff.conf - cfg.decay_step : 17'd0;
               wr_data.last_seen = item_ff.now;
            end
         end
         ST_MUL: begin
            p1_in    = PROD_W'(hit_ff.conf) * PROD_W'(Q16_ONE - alpha);
            p2_in    = PROD_W'(item_ff.conf) * PROD_W'(alpha);
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            wr_en             = 1'b1;
            wr_data.conf      = (blend_q > {2'd0, Q16_ONE}) ? Q16_ONE : blend_q[16:0];
            wr_data.hits      = (hit_ff.hits < HITS_MAX) ? hit_ff.hits + 8'd1 : hit_ff.hits;
            wr_data.last_seen = item_ff.now;
            res_in.accepted   = 1'b1;
            state_in          = ST_DONE;
         end
         ST_DONE: begin
            if (!out_vld_ff || pop) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      issue_ff     <= issue_in;
      rd_idx_ff    <= rd_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      found_ff     <= found_in;
      best_rank_ff <= best_rank_in;
      best_idx_ff  <= best_idx_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

   // slot memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
   end

endmodule

// ===== rtl/core/keyed_confidence_tracking_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_confidence_tracking_table_core
// Keyed table of event-class guesses with observe and promotion query words.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   request   | push / full           | req_action, req_form_id, req_event_kind,
//             |                       | req_confidence_in, req_now_us
//   response  | pop / empty           | rsp_accepted, rsp_promoted,
//             |                       | rsp_promoted_kind, rsp_promoted_confidence
//   registers | psel penable pwrite   | paddr, pwdata, prdata, pready (64-bit data)
//
// An observe or query word's time is set by the key scan through the
// single-read-port slot memory, one filled slot at a time until a key match;
// matching-kind observes add ST_MUL and ST_BLEND; ignored words go to ST_DONE.
// Reset empties the table at once through the fill count; no clearing pass.
// A two-word input queue and the result register let either side stall alone.
// ----------------------------------------------------------------------------
module keyed_confidence_tracking_table_core import kctt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_action,
   input  logic [31:0]           req_form_id,
   input  logic [4:0]            req_event_kind,
   input  logic [16:0]           req_confidence_in,
   input  logic [63:0]           req_now_us,
   input  logic                  pop,
   output logic                  empty,
   output logic                  rsp_accepted,
   output logic                  rsp_promoted,
   output logic [4:0]            rsp_promoted_kind,
   output logic [16:0]           rsp_promoted_confidence,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   cfg_type          cfg_ff, cfg_in;
   reg_index_type    reg_sel;
   logic             q_valid;
   logic             q_pop;
   item_type         q_item;
   result_type       rsp;
   logic [CNT_W-1:0] occupied;

   // register file
   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_W-1:3]);

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         case (reg_sel)
            REG_PROMOTABLE_MASK: cfg_in.promotable_mask = pwdata[31:0];
            REG_MIN_HITS:        cfg_in.min_hits        = pwdata[7:0];
            REG_MAX_AGE_US:      cfg_in.max_age_us      = pwdata[39:0];
            REG_MIN_CONFIDENCE:  cfg_in.min_confidence  = pwdata[16:0];
            REG_ACCEPT_FLOOR:    cfg_in.accept_floor    = pwdata[16:0];
            REG_SMOOTHING_ALPHA: cfg_in.smoothing_alpha = pwdata[16:0];
            REG_SWITCH_MARGIN:   cfg_in.switch_margin   = pwdata[16:0];
            REG_DECAY_STEP:      cfg_in.decay_step      = pwdata[16:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PROMOTABLE_MASK: prdata = {32'd0, cfg_ff.promotable_mask};
         REG_MIN_HITS:        prdata = {56'd0, cfg_ff.min_hits};
         REG_MAX_AGE_US:      prdata = {24'd0, cfg_ff.max_age_us};
         REG_MIN_CONFIDENCE:  prdata = {47'd0, cfg_ff.min_confidence};
         REG_ACCEPT_FLOOR:    prdata = {47'd0, cfg_ff.accept_floor};
         REG_SMOOTHING_ALPHA: prdata = {47'd0, cfg_ff.smoothing_alpha};
         REG_SWITCH_MARGIN:   prdata = {47'd0, cfg_ff.switch_margin};
         REG_DECAY_STEP:      prdata = {47'd0, cfg_ff.decay_step};
         default:             prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.promotable_mask <= 32'd0;
         cfg_ff.min_hits        <= 8'd3;
         cfg_ff.max_age_us      <= 40'd10000000;
         cfg_ff.min_confidence  <= 17'd34079;
         cfg_ff.accept_floor    <= 17'd19661;
         cfg_ff.smoothing_alpha <= 17'd18350;
         cfg_ff.switch_margin   <= 17'd6554;
         cfg_ff.decay_step      <= 17'd655;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify and queue
   kctt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .push          (push),
      .full          (full),
      .action        (req_action),
      .form_id       (req_form_id),
      .event_kind    (req_event_kind),
      .confidence_in (req_confidence_in),
      .now_us        (req_now_us),
      .q_pop         (q_pop),
      .q_valid       (q_valid),
      .q_item        (q_item)
   );

   // back end: table scan and update
   kctt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp      (rsp),
      .occupied (occupied)
   );

   assign rsp_accepted            = rsp.accepted;
   assign rsp_promoted            = rsp.promoted;
   assign rsp_promoted_kind       = rsp.promoted_kind;
   assign rsp_promoted_confidence = rsp.promoted_confidence;

`ifndef SYNTHESIS
   // fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      occupied <= CNT_W'(TABLE_ENTRIES))
      else $error("occupied count beyond table size");

   // at most one slot is allocated per word
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      occupied == $past(occupied) || occupied == $past(occupied) + 1'b1)
      else $error("occupied count jumped");

   // a word is either an observe or a query
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_accepted && rsp_promoted))
      else $error("result both accepted and promoted");

   // an unpromoted result carries no kind or confidence
   a_result_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_promoted) |-> (rsp_promoted_kind == 5'd0 &&
                                     rsp_promoted_confidence == 17'd0))
      else $error("stale promotion payload");
`endif

endmodule
